>>> hw/rtl/u16dec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u16dec_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned CNT_W = 32;
    localparam int unsigned CFG_W = 32;
    localparam int unsigned IDX_W = 2;

    localparam logic [15:0]     SURR_MASK = 16'hFC00;
    localparam logic [15:0]     LOW_SURR  = 16'hDC00;
    localparam logic [15:0]     HIGH_SURR = 16'hD800;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
    localparam logic [7:0]      BOM_FF    = 8'hFF;
    localparam logic [7:0]      BOM_FE    = 8'hFE;

    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_LE   = 2'd1;
    localparam logic [1:0] MODE_BE   = 2'd2;

    localparam logic [IDX_W-1:0] CFG_DECODE_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DEFAULT_ORDER = 2'd1;
    localparam logic [IDX_W-1:0] CFG_STRIP_BOM     = 2'd2;
    localparam logic [IDX_W-1:0] CFG_CHAR_LIMIT    = 2'd3;

    typedef enum logic [1:0] {
        ST_CHAR     = 2'd0,
        ST_LOW_SURR = 2'd1,
        ST_BAD_PAIR = 2'd2,
        ST_ODD_BYTE = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        t_status         status;
        logic            limit_hit;
    } t_out;

    typedef struct packed {
        logic [1:0]       decode_mode;
        logic             default_order;
        logic             strip_bom_fixed;
        logic [CNT_W-1:0] char_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       held_byte;
        logic             byte_phase;
        logic [9:0]       high_half;
        logic             pair_pending;
        logic             active_order;
        logic             at_stream_start;
        logic [CNT_W-1:0] chars_emitted;
        logic             error_hold;
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/u16dec_step.sv
`timescale 1ns / 1ps
`default_nettype none

module u16dec_step (
    input  var u16dec_pkg::t_cfg   i_cfg,
    input  var u16dec_pkg::t_state i_state,
    input  var u16dec_pkg::t_in    i_item,
    output u16dec_pkg::t_state     o_state,
    output logic                   o_res_valid,
    output u16dec_pkg::t_out       o_res
);

    logic        is_auto;
    logic        start_order;
    logic        bom_le;
    logic        bom_be;
    logic        consume;
    logic        order;
    logic [15:0] unit;
    logic        unit_low;
    logic        unit_high;
    logic [u16dec_pkg::CNT_W-1:0] cnt_inc;
    logic        eos;

    assign eos     = i_item.end_of_stream;
    assign is_auto = (i_cfg.decode_mode != u16dec_pkg::MODE_LE) &&
                     (i_cfg.decode_mode != u16dec_pkg::MODE_BE);
    assign start_order = (i_cfg.decode_mode == u16dec_pkg::MODE_LE) ? 1'b0 :
                         (i_cfg.decode_mode == u16dec_pkg::MODE_BE) ? 1'b1 :
                         i_cfg.default_order;
    assign bom_le = (i_state.held_byte == u16dec_pkg::BOM_FF) &&
                    (i_item.data_byte == u16dec_pkg::BOM_FE);
    assign bom_be = (i_state.held_byte == u16dec_pkg::BOM_FE) &&
                    (i_item.data_byte == u16dec_pkg::BOM_FF);

    always_comb begin
        consume = 1'b0;
        if (is_auto) begin
            consume = bom_le || bom_be;
        end else if (i_cfg.strip_bom_fixed) begin
            consume = ((i_cfg.decode_mode == u16dec_pkg::MODE_LE) && bom_le) ||
                      ((i_cfg.decode_mode == u16dec_pkg::MODE_BE) && bom_be);
        end
    end

    always_comb begin
        if (i_cfg.decode_mode == u16dec_pkg::MODE_LE) begin
            order = 1'b0;
        end else if (i_cfg.decode_mode == u16dec_pkg::MODE_BE) begin
            order = 1'b1;
        end else if (i_state.at_stream_start) begin
            order = bom_le ? 1'b0 : (bom_be ? 1'b1 : start_order);
        end else begin
            order = i_state.active_order;
        end
    end

    assign unit      = order ? {i_state.held_byte, i_item.data_byte}
                             : {i_item.data_byte, i_state.held_byte};
    assign unit_low  = (unit & u16dec_pkg::SURR_MASK) == u16dec_pkg::LOW_SURR;
    assign unit_high = (unit & u16dec_pkg::SURR_MASK) == u16dec_pkg::HIGH_SURR;
    assign cnt_inc   = i_state.chars_emitted + 1'b1;

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '{code_point: '0, status: u16dec_pkg::ST_CHAR, limit_hit: 1'b0};

        if (i_state.error_hold) begin
            // drop bytes until end of stream
        end else if (!i_state.byte_phase) begin
            if (eos) begin
                o_res_valid  = 1'b1;
                o_res.status = u16dec_pkg::ST_ODD_BYTE;
            end else begin
                o_state.held_byte  = i_item.data_byte;
                o_state.byte_phase = 1'b1;
            end
        end else begin
            o_state.byte_phase = 1'b0;
            if (i_state.at_stream_start) begin
                o_state.at_stream_start = 1'b0;
                o_state.active_order    = order;
            end
            if (!(i_state.at_stream_start && consume)) begin
                if (i_state.pair_pending) begin
                    o_state.pair_pending = 1'b0;
                    o_state.high_half    = '0;
                    o_res_valid          = 1'b1;
                    if (unit_low) begin
                        o_res.code_point = u16dec_pkg::SUPP_BASE +
                                           {1'b0, i_state.high_half, unit[9:0]};
                    end else begin
                        o_res.status = u16dec_pkg::ST_BAD_PAIR;
                    end
                end else if (unit_low) begin
                    o_res_valid  = 1'b1;
                    o_res.status = u16dec_pkg::ST_LOW_SURR;
                end else if (unit_high) begin
                    o_state.high_half    = unit[9:0];
                    o_state.pair_pending = 1'b1;
                    if (eos) begin
                        o_res_valid  = 1'b1;
                        o_res.status = u16dec_pkg::ST_BAD_PAIR;
                    end
                end else begin
                    o_res_valid      = 1'b1;
                    o_res.code_point = {5'd0, unit};
                end

                if (o_res_valid) begin
                    if (o_res.status == u16dec_pkg::ST_CHAR) begin
                        o_state.chars_emitted = cnt_inc;
                        if ((i_cfg.char_limit != '0) && (cnt_inc == i_cfg.char_limit)) begin
                            o_res.limit_hit       = 1'b1;
                            o_state.chars_emitted = '0;
                        end
                    end else if (!eos) begin
                        o_state.error_hold = 1'b1;
                    end
                end
            end
        end

        if (eos) begin
            o_state.held_byte       = '0;
            o_state.byte_phase      = 1'b0;
            o_state.high_half       = '0;
            o_state.pair_pending    = 1'b0;
            o_state.at_stream_start = 1'b1;
            o_state.chars_emitted   = '0;
            o_state.error_hold      = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/utf16_stream_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial UTF-16 decoder: takes one byte per cycle while o_stall is low, pairs bytes into 16-bit
// units in little or big endian order (picked by a leading byte order mark in
// auto mode), joins surrogate pairs and gives at most one result per byte, registered
// and shown in the cycle after the byte is taken. The rate is one byte per cycle while o_stall
// is low, set by the single stream state register that each byte updates. The result register
// lets the next byte enter while a result waits; o_stall rises only while a
// result is held and the consumer stalls. After an error, bytes are dropped
// until the byte that marks end of stream. Write configuration only while idle.

module utf16_stream_decoder_core (
    input  var logic                                i_clk,
    input  var logic                                i_rst_n,
    input  var logic                                i_cfg_we,
    input  var logic [u16dec_pkg::IDX_W-1:0]        i_cfg_idx,
    input  var logic [u16dec_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  var logic                                i_valid,
    output logic                                    o_stall,
    input  var u16dec_pkg::t_in                     i_data,
    output logic                                    o_valid,
    input  var logic                                i_stall,
    output u16dec_pkg::t_out                        o_data
);

    u16dec_pkg::t_cfg   r_cfg;
    u16dec_pkg::t_state r_state;
    u16dec_pkg::t_state n_state;
    logic               r_out_valid;
    u16dec_pkg::t_out   r_out;
    logic               res_valid;
    u16dec_pkg::t_out   res;
    logic               accept;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    u16dec_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_item      (i_data),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{decode_mode: u16dec_pkg::MODE_AUTO, default_order: 1'b0,
                       strip_bom_fixed: 1'b0, char_limit: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                u16dec_pkg::CFG_DECODE_MODE:   r_cfg.decode_mode     <= i_cfg_wdata[1:0];
                u16dec_pkg::CFG_DEFAULT_ORDER: r_cfg.default_order   <= i_cfg_wdata[0];
                u16dec_pkg::CFG_STRIP_BOM:     r_cfg.strip_bom_fixed <= i_cfg_wdata[0];
                u16dec_pkg::CFG_CHAR_LIMIT:    r_cfg.char_limit      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{held_byte: '0, byte_phase: 1'b0, high_half: '0,
                         pair_pending: 1'b0, active_order: 1'b0,
                         at_stream_start: 1'b1, chars_emitted: '0, error_hold: 1'b0};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out <= res;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with empty result register");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status != u16dec_pkg::ST_CHAR) |->
            (o_data.code_point == '0 && !o_data.limit_hit))
        else $error("error result carries data");

    a_no_surrogate_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == u16dec_pkg::ST_CHAR) |->
            !(o_data.code_point[20:16] == 5'd0 && o_data.code_point[15:11] == 5'b11011))
        else $error("surrogate code emitted as char");

    a_limit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res_valid && res.limit_hit) |=> (r_state.chars_emitted == '0))
        else $error("char count not restarted after limit");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.error_hold |-> (!r_state.byte_phase && !r_state.pair_pending))
        else $error("error hold with partial unit pending");

endmodule

`default_nettype wire

>>> tb/utf16_stream_decoder_core_tb.sv
`timescale 1ns / 1ps

module utf16_stream_decoder_core_tb;
    import u16dec_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam logic       ORDER_LE     = 1'b0;
    localparam logic       ORDER_BE     = 1'b1;
    localparam int         RANDOM_ITEMS = 1350;
    localparam int         QUIET_AFTER  = 1150;
    localparam int         PHASE_ITEMS  = 120;
    localparam int         DRAIN_LIMIT  = 2000;
    localparam int         HOLD_CYCLES  = 80;

    class utf16_decode_scoreboard;
        t_cfg        cfg;
        t_state      st;
        t_out        pending_chars[$];
        int unsigned mismatches;
        int unsigned chars_seen;
        int unsigned errors_seen;
        int unsigned limit_hits;

        function new();
            cfg = '0;
            st = '0;
            st.at_stream_start = 1'b1;
        endfunction

        function void set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
            case (idx)
                CFG_DECODE_MODE:   cfg.decode_mode = val[1:0];
                CFG_DEFAULT_ORDER: cfg.default_order = val[0];
                CFG_STRIP_BOM:     cfg.strip_bom_fixed = val[0];
                default:           cfg.char_limit = val[CNT_W-1:0];
            endcase
        endfunction

        function logic fresh_order();
            if (cfg.decode_mode == MODE_LE) return ORDER_LE;
            if (cfg.decode_mode == MODE_BE) return ORDER_BE;
            return cfg.default_order;
        endfunction

        function void restart_stream();
            logic keep;
            keep = st.active_order;
            st = '0;
            st.at_stream_start = 1'b1;
            st.active_order = keep;
        endfunction

        function void push_result(input t_out res);
            pending_chars.push_back(res);
            if (res.status == ST_CHAR) chars_seen++;
            else errors_seen++;
            if (res.limit_hit) limit_hits++;
        endfunction

        // Returns 0 when the byte is dropped under an error hold.
        function bit note_byte(input t_in req);
            logic [7:0]  first;
            logic [15:0] unit;
            logic        order;
            logic        eos;
            logic        is_auto;
            logic        mark_le;
            logic        mark_be;
            logic        take_mark;
            t_out        res;
            eos = req.end_of_stream;
            is_auto = (cfg.decode_mode == MODE_AUTO) || (cfg.decode_mode == MODE_UNUSED);
            res = '0;
            res.status = ST_CHAR;
            if (st.error_hold) begin
                if (eos) restart_stream();
                return 1'b0;
            end
            if (!st.byte_phase) begin
                if (eos) begin
                    res.status = ST_ODD_BYTE;
                    push_result(res);
                    restart_stream();
                    return 1'b1;
                end
                st.held_byte = req.data_byte;
                st.byte_phase = 1'b1;
                return 1'b1;
            end
            st.byte_phase = 1'b0;
            first = st.held_byte;
            if (st.at_stream_start) begin
                mark_le = (first == BOM_FF) && (req.data_byte == BOM_FE);
                mark_be = (first == BOM_FE) && (req.data_byte == BOM_FF);
                take_mark = 1'b0;
                st.at_stream_start = 1'b0;
                st.active_order = fresh_order();
                if (is_auto) begin
                    if (mark_le) begin
                        st.active_order = ORDER_LE;
                        take_mark = 1'b1;
                    end else if (mark_be) begin
                        st.active_order = ORDER_BE;
                        take_mark = 1'b1;
                    end
                end else if (cfg.strip_bom_fixed) begin
                    take_mark = ((cfg.decode_mode == MODE_LE) && mark_le) ||
                                ((cfg.decode_mode == MODE_BE) && mark_be);
                end
                if (take_mark) begin
                    if (eos) restart_stream();
                    return 1'b1;
                end
            end
            if (cfg.decode_mode == MODE_LE) order = ORDER_LE;
            else if (cfg.decode_mode == MODE_BE) order = ORDER_BE;
            else order = st.active_order;
            unit = (order == ORDER_BE) ? {first, req.data_byte} : {req.data_byte, first};

            if (st.pair_pending) begin
                st.pair_pending = 1'b0;
                if ((unit & SURR_MASK) == LOW_SURR)
                    res.code_point = SUPP_BASE + {st.high_half, unit[9:0]};
                else
                    res.status = ST_BAD_PAIR;
                st.high_half = '0;
            end else if ((unit & SURR_MASK) == LOW_SURR) begin
                res.status = ST_LOW_SURR;
            end else if ((unit & SURR_MASK) == HIGH_SURR) begin
                st.high_half = unit[9:0];
                st.pair_pending = 1'b1;
                if (!eos) return 1'b1;
                res.status = ST_BAD_PAIR;
            end else begin
                res.code_point = CP_W'(unit);
            end

            if (res.status == ST_CHAR) begin
                st.chars_emitted = st.chars_emitted + 1;
                if (cfg.char_limit != '0 && st.chars_emitted == cfg.char_limit) begin
                    res.limit_hit = 1'b1;
                    st.chars_emitted = '0;
                end
            end else begin
                res.code_point = '0;
            end
            push_result(res);
            if (eos) restart_stream();
            else if (res.status != ST_CHAR) st.error_hold = 1'b1;
            return 1'b1;
        endfunction

        function void check_char(input t_out got);
            t_out want;
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cp=%h status=%0d hit=%b",
                             got.code_point, got.status, got.limit_hit);
                return;
            end
            want = pending_chars.pop_front();
            if (got.code_point !== want.code_point || got.status !== want.status ||
                got.limit_hit !== want.limit_hit) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected cp=%h status=%0d hit=%b, got cp=%h status=%0d hit=%b",
                             want.code_point, want.status, want.limit_hit,
                             got.code_point, got.status, got.limit_hit);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    t_in              i_data = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    t_out             o_data;

    utf16_stream_decoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    utf16_decode_scoreboard sb = new();

    logic [7:0] stream_bytes[$];
    bit         idle_on = 1'b1;
    bit         long_hold_req = 1'b0;
    int         useful_bytes = 0;
    int         total_bytes = 0;
    int         streams_sent = 0;
    int         settings_applied = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Timeout waiting for the decoder to drain");
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_char(o_data);
    end

    // Consumer side: random stall bursts, plus one long hold on request.
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input t_in req);
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        total_bytes++;
        if (sb.note_byte(req)) useful_bytes++;
    endtask

    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic run_bytes(input bit with_eos);
        t_in req;
        int  k;
        for (k = 0; k < stream_bytes.size(); k++) begin
            req.data_byte = stream_bytes[k];
            req.end_of_stream = with_eos && (k == stream_bytes.size() - 1);
            maybe_gap();
            send_byte(req);
        end
        streams_sent++;
    endtask

    // Hold off until every expected result is in, then let the pipe empty.
    task automatic settle();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (sb.pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [1:0] mode, input logic dflt, input logic strip,
                                  input logic [CNT_W-1:0] limit);
        write_reg(CFG_DECODE_MODE, CFG_W'(mode));
        write_reg(CFG_DEFAULT_ORDER, CFG_W'(dflt));
        write_reg(CFG_STRIP_BOM, CFG_W'(strip));
        write_reg(CFG_CHAR_LIMIT, CFG_W'(limit));
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic pick_settings(input int phase);
        logic [CNT_W-1:0] limit;
        case (phase)
            0: apply_settings(MODE_AUTO, ORDER_LE, 1'b0, '0);
            1: apply_settings(MODE_AUTO, ORDER_BE, 1'b0, 32'd1);
            2: apply_settings(MODE_LE, ORDER_LE, 1'b1, 32'd3);
            3: apply_settings(MODE_BE, ORDER_BE, 1'b1, 32'd5);
            4: apply_settings(MODE_LE, ORDER_BE, 1'b0, 32'd2);
            5: apply_settings(MODE_BE, ORDER_LE, 1'b0, 32'hFFFF_FFFF);
            6: apply_settings(MODE_UNUSED, ORDER_BE, 1'b1, 32'd4);
            7: apply_settings(MODE_AUTO, ORDER_LE, 1'b1, 32'd1);
            default: begin
                case ($urandom_range(0, 3))
                    0: limit = '0;
                    1: limit = 32'd1;
                    2: limit = CNT_W'($urandom_range(2, 9));
                    default: limit = $urandom;
                endcase
                apply_settings(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), limit);
            end
        endcase
    endtask

    function automatic void push_unit(input logic [15:0] u, input logic order);
        if (order == ORDER_BE) begin
            stream_bytes.push_back(u[15:8]);
            stream_bytes.push_back(u[7:0]);
        end else begin
            stream_bytes.push_back(u[7:0]);
            stream_bytes.push_back(u[15:8]);
        end
    endfunction

    function automatic void push_char(input logic order);
        logic [15:0] u;
        case ($urandom_range(0, 10))
            0, 1, 2, 3: u = 16'($urandom_range(0, 16'h007F));
            4, 5, 6:    u = 16'($urandom_range(16'h0080, 16'hD7FF));
            7:          u = 16'($urandom_range(16'hE000, 16'hFFFF));
            8, 9: begin
                push_unit(HIGH_SURR | 16'($urandom_range(0, 1023)), order);
                u = LOW_SURR | 16'($urandom_range(0, 1023));
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: u = 16'h0000;
                    1: u = 16'hFFFF;
                    2: u = 16'hD7FF;
                    3: u = 16'hE000;
                    4: begin
                        push_unit(HIGH_SURR, order);
                        u = LOW_SURR;
                    end
                    default: begin
                        push_unit(HIGH_SURR | 16'h03FF, order);
                        u = LOW_SURR | 16'h03FF;
                    end
                endcase
            end
        endcase
        push_unit(u, order);
    endfunction

    // Build text in the order the decoder should pick, optionally with one flaw.
    task automatic build_text(input bit broken);
        logic order;
        bit   is_auto;
        int   n_units;
        int   flaw;
        int   flaw_at;
        int   k;
        stream_bytes.delete();
        is_auto = (sb.cfg.decode_mode == MODE_AUTO) || (sb.cfg.decode_mode == MODE_UNUSED);
        order = sb.fresh_order();
        case ($urandom_range(0, 3))
            1: begin
                stream_bytes.push_back(BOM_FF);
                stream_bytes.push_back(BOM_FE);
                if (is_auto) order = ORDER_LE;
            end
            2: begin
                stream_bytes.push_back(BOM_FE);
                stream_bytes.push_back(BOM_FF);
                if (is_auto) order = ORDER_BE;
            end
            default: ;
        endcase
        n_units = $urandom_range(1, 12);
        flaw = $urandom_range(0, 3);
        flaw_at = broken ? $urandom_range(0, n_units - 1) : -1;
        for (k = 0; k < n_units; k++) begin
            if (k == flaw_at && flaw == 0)
                push_unit(LOW_SURR | 16'($urandom_range(0, 1023)), order);
            if (k == flaw_at && flaw == 1) begin
                push_unit(HIGH_SURR | 16'($urandom_range(0, 1023)), order);
                push_unit(16'($urandom_range(0, 16'hD7FF)), order);
            end
            push_char(order);
        end
        if (broken && flaw == 2) push_unit(HIGH_SURR | 16'($urandom_range(0, 1023)), order);
        if (broken && flaw == 3) stream_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_noise();
        int n;
        int k;
        stream_bytes.delete();
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) stream_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int phase;
        int rand_start;
        int goal;
        int kind;
        int leftover;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // mark, ASCII and the highest supplementary code point
        stream_bytes = '{BOM_FF, BOM_FE, 8'h41, 8'h00, 8'hFF, 8'hDB, 8'hFF, 8'hDF};
        run_bytes(1'b1);
        // lone mark closing the stream
        stream_bytes = '{BOM_FE, BOM_FF};
        run_bytes(1'b1);
        // odd trailing byte
        stream_bytes = '{8'h7F};
        run_bytes(1'b1);
        // stray low surrogate, then drop until end of stream
        stream_bytes = '{8'h00, 8'hDC, 8'h41, 8'h00};
        run_bytes(1'b1);
        // high surrogate as the last unit
        stream_bytes = '{8'h00, 8'hD8};
        run_bytes(1'b1);
        // high surrogate followed by a plain unit
        stream_bytes = '{8'h00, 8'hD8, 8'h41, 8'h00, 8'hFF};
        run_bytes(1'b1);
        // odd trailing byte with a pair pending
        stream_bytes = '{8'h00, 8'hD8, 8'hFF};
        run_bytes(1'b1);

        phase = 0;
        rand_start = useful_bytes;
        while (useful_bytes - rand_start < RANDOM_ITEMS) begin
            settle();
            pick_settings(phase);
            if (useful_bytes - rand_start >= QUIET_AFTER) idle_on = 1'b0;
            else if (phase == 3) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 3) long_hold_req = 1'b1;
            goal = useful_bytes + PHASE_ITEMS;
            while (useful_bytes < goal && useful_bytes - rand_start < RANDOM_ITEMS) begin
                kind = $urandom_range(0, 19);
                if (kind < 14) build_text(1'b0);
                else if (kind < 17) build_text(1'b1);
                else build_noise();
                run_bytes($urandom_range(0, 24) != 0);
            end
            // leave a stream open across the register change
            if ($urandom_range(0, 1) == 0) begin
                build_text(1'b0);
                run_bytes(1'b0);
            end
            phase++;
        end
        settle();
        leftover = sb.pending_chars.size();
        if (leftover != 0) $display("%0d expected results never arrived", leftover);

        $display("Sent %0d bytes in %0d streams under %0d register settings",
                 total_bytes, streams_sent, settings_applied);
        $display("Checked %0d characters, %0d error reports and %0d limit flags",
                 sb.chars_seen, sb.errors_seen, sb.limit_hits);
        if (sb.mismatches == 0 && leftover == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
